// ----- design/dcma_pkg.sv -----
// Shared types and constants for the dual-channel moving average.
// Used by dcma_ctrl, dcma_datapath and the top level; depends on nothing.
package dcma_pkg;

  localparam int HUM_W     = 10;
  localparam int TEMP_W    = 11;
  localparam int AVG_W     = 14;
  localparam int CNT_OUT_W = 6;

  localparam int AVG_H_MAX     = 16383;
  localparam int AVG_T_MAX     = 8191;
  localparam int AVG_T_MIN_MAG = 8192;

  typedef struct packed {
    logic accept;
    logic update;
    logic prep;
    logic step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

// ----- design/dcma_ctrl.sv -----
// Sequencer for the moving average: request handshakes and command strobes.
// Depends on dcma_pkg for cmd_t and sts_t.
module dcma_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  dcma_pkg::sts_t sts,
  output dcma_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPD,
    S_PREP,
    S_DIV,
    S_PUT
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   put_ok;

  assign put_ok    = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.accept   = (state_r == S_IDLE) && in_valid;
    cmd.update   = (state_r == S_UPD);
    cmd.prep     = (state_r == S_PREP);
    cmd.step     = (state_r == S_DIV) && !sts.div_done;
    cmd.load_out = (state_r == S_PUT) && put_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) state_r <= S_UPD;
        end
        S_UPD:  state_r <= S_PREP;
        S_PREP: state_r <= S_DIV;
        S_DIV: begin
          if (sts.div_done) state_r <= S_PUT;
        end
        S_PUT: begin
          if (put_ok) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- design/dcma_datapath.sv -----
// Rings, running sums, fill count, two-lane serial divider and result registers.
// Depends on dcma_pkg; driven by commands from dcma_ctrl.
module dcma_datapath #(
  parameter int WINDOW = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  dcma_pkg::cmd_t                      cmd,
  output dcma_pkg::sts_t                      sts,
  input  logic [dcma_pkg::HUM_W-1:0]          in_humidity_tenths,
  input  logic                                in_humidity_ok,
  input  logic signed [dcma_pkg::TEMP_W-1:0]  in_temp_tenths,
  input  logic                                in_temp_ok,
  output logic [dcma_pkg::AVG_W-1:0]          out_avg_humidity,
  output logic signed [dcma_pkg::AVG_W-1:0]   out_avg_temp,
  output logic                                out_avg_valid,
  output logic [dcma_pkg::CNT_OUT_W-1:0]      out_stored_count
);

  localparam int HW  = dcma_pkg::HUM_W;
  localparam int TW  = dcma_pkg::TEMP_W;
  localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW  = $clog2(WINDOW + 1);
  localparam int HSW = $clog2(WINDOW * 1023 + 1);
  localparam int TSW = $clog2(WINDOW * 1024) + 1;
  localparam int NW  = $clog2(WINDOW * 10240 + 1);
  localparam int KW  = $clog2(NW + 1);

  logic [HW-1:0]        hum_ring [WINDOW];
  logic signed [TW-1:0] temp_ring [WINDOW];

  logic [HW-1:0]         h_in_r;
  logic signed [TW-1:0]  t_in_r;
  logic                  store_r;
  logic [HW-1:0]         h_old_r;
  logic signed [TW-1:0]  t_old_r;

  logic [PW-1:0]         wpos_r;
  logic [CW-1:0]         fill_r;
  logic [HSW-1:0]        hsum_r;
  logic signed [TSW-1:0] tsum_r;
  logic                  full;

  logic [HSW-1:0]        hsum_nxt;
  logic signed [TSW-1:0] tsum_nxt;
  logic signed [TSW-1:0] t_new_ext;
  logic signed [TSW-1:0] t_old_ext;

  logic [NW-1:0]  hnum_r;
  logic [NW-1:0]  tnum_r;
  logic [CW-1:0]  hrem_r;
  logic [CW-1:0]  trem_r;
  logic [CW-1:0]  den_r;
  logic           tneg_r;
  logic [KW-1:0]  kcnt_r;

  logic [NW-1:0]  hnum_nxt;
  logic [NW-1:0]  tnum_nxt;
  logic [TSW-1:0] tmag;
  logic [CW:0]    htrial;
  logic [CW:0]    ttrial;
  logic [CW:0]    hdiff;
  logic [CW:0]    tdiff;
  logic           hbit;
  logic           tbit;

  logic [dcma_pkg::AVG_W-1:0] h_sat;
  logic [dcma_pkg::AVG_W-1:0] t_sat;

  assign full      = (fill_r == CW'(WINDOW));
  assign t_new_ext = TSW'(t_in_r);
  assign t_old_ext = TSW'(t_old_r);

  always_comb begin
    hsum_nxt = hsum_r + HSW'(h_in_r);
    tsum_nxt = tsum_r + t_new_ext;
    if (full) begin
      hsum_nxt = hsum_nxt - HSW'(h_old_r);
      tsum_nxt = tsum_nxt - t_old_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      h_in_r  <= in_humidity_tenths;
      t_in_r  <= in_temp_tenths;
      h_old_r <= hum_ring[wpos_r];
      t_old_r <= temp_ring[wpos_r];
    end
    if (cmd.update && store_r) begin
      hum_ring[wpos_r]  <= h_in_r;
      temp_ring[wpos_r] <= t_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= 1'b0;
      wpos_r  <= '0;
      fill_r  <= '0;
      hsum_r  <= '0;
      tsum_r  <= '0;
    end else begin
      if (cmd.accept) store_r <= in_humidity_ok && in_temp_ok;
      if (cmd.update && store_r) begin
        hsum_r <= hsum_nxt;
        tsum_r <= tsum_nxt;
        wpos_r <= (wpos_r == PW'(WINDOW - 1)) ? '0 : wpos_r + PW'(1);
        if (!full) fill_r <= fill_r + CW'(1);
      end
    end
  end

  // sum * 10 as (x << 3) + (x << 1), magnitude for the signed lane
  assign tmag     = tsum_r[TSW-1] ? TSW'(-tsum_r) : TSW'(tsum_r);
  assign hnum_nxt = (NW'(hsum_r) << 3) + (NW'(hsum_r) << 1);
  assign tnum_nxt = (NW'(tmag) << 3) + (NW'(tmag) << 1);

  assign htrial = {hrem_r, hnum_r[NW-1]};
  assign ttrial = {trem_r, tnum_r[NW-1]};
  assign hdiff  = htrial - {1'b0, den_r};
  assign tdiff  = ttrial - {1'b0, den_r};
  assign hbit   = (htrial >= {1'b0, den_r});
  assign tbit   = (ttrial >= {1'b0, den_r});

  assign sts.div_done = (kcnt_r == KW'(NW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kcnt_r <= '0;
    end else if (cmd.prep) begin
      kcnt_r <= '0;
    end else if (cmd.step) begin
      kcnt_r <= kcnt_r + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      hnum_r <= hnum_nxt;
      tnum_r <= tnum_nxt;
      hrem_r <= '0;
      trem_r <= '0;
      den_r  <= fill_r;
      tneg_r <= tsum_r[TSW-1];
    end else if (cmd.step) begin
      hnum_r <= {hnum_r[NW-2:0], hbit};
      tnum_r <= {tnum_r[NW-2:0], tbit};
      hrem_r <= hbit ? hdiff[CW-1:0] : htrial[CW-1:0];
      trem_r <= tbit ? tdiff[CW-1:0] : ttrial[CW-1:0];
    end
  end

  always_comb begin
    if (hnum_r > NW'(dcma_pkg::AVG_H_MAX)) begin
      h_sat = dcma_pkg::AVG_W'(dcma_pkg::AVG_H_MAX);
    end else begin
      h_sat = hnum_r[dcma_pkg::AVG_W-1:0];
    end
    if (tneg_r) begin
      if (tnum_r > NW'(dcma_pkg::AVG_T_MIN_MAG)) begin
        t_sat = dcma_pkg::AVG_W'(-dcma_pkg::AVG_T_MIN_MAG);
      end else begin
        t_sat = -tnum_r[dcma_pkg::AVG_W-1:0];
      end
    end else begin
      if (tnum_r > NW'(dcma_pkg::AVG_T_MAX)) begin
        t_sat = dcma_pkg::AVG_W'(dcma_pkg::AVG_T_MAX);
      end else begin
        t_sat = tnum_r[dcma_pkg::AVG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_avg_valid    <= (den_r != '0);
      out_stored_count <= dcma_pkg::CNT_OUT_W'(den_r);
      out_avg_humidity <= (den_r != '0) ? h_sat : '0;
      out_avg_temp     <= (den_r != '0) ? t_sat : '0;
    end
  end

endmodule

// ----- design/dual_channel_moving_average_top.sv -----
// Top level of the dual-channel moving average: controller plus datapath.
// Depends on dcma_pkg, dcma_ctrl and dcma_datapath.
//
//   channel  ports                                         direction
//   in       in_valid, in_stall, humidity/temp fields      request in
//   out      out_valid, out_stall, averages, count         request out
//
// A request passes through S_UPD, S_PREP, S_DIV and S_PUT after it is accepted;
// in_stall stays high until S_PUT loads its result, so the next request is not
// taken before that. The bit-per-cycle divider that serves both channels yields
// NW = clog2(WINDOW*10240+1) quotient bits (20 at WINDOW = 60).
// Synchronous active-low reset clears sums, fill count and write position;
// ring contents are not cleared. A request is taken while a result still
// waits; the next result holds back until out_stall drops.
module dual_channel_moving_average_top #(
  parameter int WINDOW = 60
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [dcma_pkg::HUM_W-1:0]          in_humidity_tenths,
  input  logic                                in_humidity_ok,
  input  logic signed [dcma_pkg::TEMP_W-1:0]  in_temp_tenths,
  input  logic                                in_temp_ok,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [dcma_pkg::AVG_W-1:0]          out_avg_humidity,
  output logic signed [dcma_pkg::AVG_W-1:0]   out_avg_temp,
  output logic                                out_avg_valid,
  output logic [dcma_pkg::CNT_OUT_W-1:0]      out_stored_count
);

  dcma_pkg::cmd_t cmd;
  dcma_pkg::sts_t sts;

  dcma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcma_datapath #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_humidity_tenths (in_humidity_tenths),
    .in_humidity_ok     (in_humidity_ok),
    .in_temp_tenths     (in_temp_tenths),
    .in_temp_ok         (in_temp_ok),
    .out_avg_humidity   (out_avg_humidity),
    .out_avg_temp       (out_avg_temp),
    .out_avg_valid      (out_avg_valid),
    .out_stored_count   (out_stored_count)
  );

endmodule
